FILE: hdl/ffra_pkg.sv
package ffra_pkg;

  localparam int MAX_COLUMNS_DEF = 16;
  localparam int MAX_ROWS_DEF    = 16;
  localparam int PAGE_COUNT_DEF  = 2;

  localparam int DIM_W = 5;

  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_PLACE = 1'b1;

  typedef enum logic [2:0] {
    REG_SECOND_EN   = 3'd0,
    REG_FIRST_COLS  = 3'd1,
    REG_FIRST_ROWS  = 3'd2,
    REG_SECOND_COLS = 3'd3,
    REG_SECOND_ROWS = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic             second_en;
    logic [DIM_W-1:0] first_cols;
    logic [DIM_W-1:0] first_rows;
    logic [DIM_W-1:0] second_cols;
    logic [DIM_W-1:0] second_rows;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAGE,
    S_FETCH,
    S_DRAIN,
    S_SCAN,
    S_MREAD,
    S_MWRITE,
    S_DONE
  } state_t;

endpackage

FILE: hdl/ffra_bitmap.sv
module ffra_bitmap #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;

  // An entry that has not been written since reset or the last clear reads as free.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

FILE: hdl/ffra_seq.sv
module ffra_seq #(
  parameter int MAX_COLUMNS = ffra_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = ffra_pkg::MAX_ROWS_DEF,
  parameter int PAGE_COUNT  = ffra_pkg::PAGE_COUNT_DEF,
  localparam int DEPTH = PAGE_COUNT * MAX_ROWS,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ffra_pkg::cfg_t         cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_command,
  input  logic [4:0]             in_width,
  input  logic [4:0]             in_height,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_placed,
  output logic                   out_page,
  output logic [3:0]             out_col,
  output logic [3:0]             out_row,
  output logic                   bm_clear,
  output logic                   bm_rd_en,
  output logic [AW-1:0]          bm_rd_addr,
  input  logic [MAX_COLUMNS-1:0] bm_rd_data,
  output logic                   bm_wr_en,
  output logic [AW-1:0]          bm_wr_addr,
  output logic [MAX_COLUMNS-1:0] bm_wr_data
);

  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int RW = $clog2(MAX_ROWS + 1);

  ffra_pkg::state_t state, state_next;

  logic [4:0]             w, w_next;
  logic [4:0]             h, h_next;
  logic                   page, page_next;
  logic [CW-1:0]          cols, cols_next;
  logic [RW-1:0]          rows, rows_next;
  logic [RW-1:0]          y, y_next;
  logic [CW-1:0]          x, x_next;
  logic [4:0]             k, k_next;
  logic [MAX_COLUMNS-1:0] acc, acc_next;
  logic                   fetch_d;
  logic                   res_placed, res_placed_next;
  logic                   res_page, res_page_next;
  logic [3:0]             res_col, res_col_next;
  logic [3:0]             res_row, res_row_next;
  logic                   load_out;

  logic [4:0]             raw_cols;
  logic [4:0]             raw_rows;
  logic [CW-1:0]          page_cols;
  logic [RW-1:0]          page_rows;
  logic [MAX_COLUMNS-1:0] win;
  logic [AW-1:0]          row_addr;
  logic                   more_pages;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffra_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    raw_cols   = page ? cfg.second_cols : cfg.first_cols;
    raw_rows   = page ? cfg.second_rows : cfg.first_rows;
    page_cols  = (int'(raw_cols) > MAX_COLUMNS) ? CW'(MAX_COLUMNS) : CW'(raw_cols);
    page_rows  = (int'(raw_rows) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(raw_rows);
    win        = (~({MAX_COLUMNS{1'b1}} << w)) << x;
    row_addr   = AW'(int'(page) * MAX_ROWS + int'(y) + int'(k));
    more_pages = (page == 1'b0) && (PAGE_COUNT > 1) && cfg.second_en;

    state_next      = state;
    w_next          = w;
    h_next          = h;
    page_next       = page;
    cols_next       = cols;
    rows_next       = rows;
    y_next          = y;
    x_next          = x;
    k_next          = k;
    acc_next        = fetch_d ? (acc | bm_rd_data) : acc;
    res_placed_next = res_placed;
    res_page_next   = res_page;
    res_col_next    = res_col;
    res_row_next    = res_row;
    load_out        = 1'b0;
    in_ready        = 1'b0;
    bm_clear        = 1'b0;
    bm_rd_en        = 1'b0;
    bm_wr_en        = 1'b0;
    bm_rd_addr      = row_addr;
    bm_wr_addr      = row_addr;
    bm_wr_data      = bm_rd_data | win;

    case (state)
      ffra_pkg::S_IDLE: begin
        in_ready        = 1'b1;
        res_placed_next = 1'b0;
        res_page_next   = 1'b0;
        res_col_next    = '0;
        res_row_next    = '0;
        if (in_valid) begin
          if (in_command == ffra_pkg::CMD_CLEAR) begin
            bm_clear   = 1'b1;
            state_next = ffra_pkg::S_DONE;
          end else begin
            w_next     = (in_width == 5'd0) ? 5'd1 : in_width;
            h_next     = (in_height == 5'd0) ? 5'd1 : in_height;
            page_next  = 1'b0;
            state_next = ffra_pkg::S_PAGE;
          end
        end
      end
      ffra_pkg::S_PAGE: begin
        cols_next = page_cols;
        rows_next = page_rows;
        y_next    = '0;
        x_next    = '0;
        k_next    = '0;
        acc_next  = '0;
        if (int'(w) <= int'(page_cols) && int'(h) <= int'(page_rows)) begin
          state_next = ffra_pkg::S_FETCH;
        end else if (more_pages) begin
          page_next = 1'b1;
        end else begin
          state_next = ffra_pkg::S_DONE;
        end
      end
      ffra_pkg::S_FETCH: begin
        bm_rd_en = 1'b1;
        k_next   = k + 5'd1;
        if (int'(k) + 1 == int'(h)) begin
          state_next = ffra_pkg::S_DRAIN;
        end
      end
      ffra_pkg::S_DRAIN: begin
        x_next     = '0;
        state_next = ffra_pkg::S_SCAN;
      end
      ffra_pkg::S_SCAN: begin
        k_next = '0;
        if ((acc & win) == '0) begin
          res_placed_next = 1'b1;
          res_page_next   = page;
          res_col_next    = 4'(x);
          res_row_next    = 4'(y);
          state_next      = ffra_pkg::S_MREAD;
        end else if (int'(x) + int'(w) < int'(cols)) begin
          x_next = x + CW'(1);
        end else if (int'(y) + int'(h) < int'(rows)) begin
          y_next     = y + RW'(1);
          acc_next   = '0;
          state_next = ffra_pkg::S_FETCH;
        end else if (more_pages) begin
          page_next  = 1'b1;
          state_next = ffra_pkg::S_PAGE;
        end else begin
          state_next = ffra_pkg::S_DONE;
        end
      end
      ffra_pkg::S_MREAD: begin
        bm_rd_en   = 1'b1;
        state_next = ffra_pkg::S_MWRITE;
      end
      ffra_pkg::S_MWRITE: begin
        bm_wr_en = 1'b1;
        k_next   = k + 5'd1;
        if (int'(k) + 1 == int'(h)) begin
          state_next = ffra_pkg::S_DONE;
        end else begin
          state_next = ffra_pkg::S_MREAD;
        end
      end
      ffra_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ffra_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ffra_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fetch_d   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      fetch_d <= (state == ffra_pkg::S_FETCH);
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    w          <= w_next;
    h          <= h_next;
    page       <= page_next;
    cols       <= cols_next;
    rows       <= rows_next;
    y          <= y_next;
    x          <= x_next;
    k          <= k_next;
    acc        <= acc_next;
    res_placed <= res_placed_next;
    res_page   <= res_page_next;
    res_col    <= res_col_next;
    res_row    <= res_row_next;
    if (load_out) begin
      out_placed <= res_placed;
      out_page   <= res_page;
      out_col    <= res_col;
      out_row    <= res_row;
    end
  end

endmodule

FILE: hdl/first_fit_rectangle_allocator_core.sv
// Channel    Direction  Handshake                    Payload
// s_*        in         s_tvalid / s_tready          tuser: command; tdata: width, height
// m_*        out        m_tvalid / m_tready          tuser: placed; tdata: page, column, row
// APB        in         psel & penable & pwrite      five configuration registers at 4*i
//
// A clear request goes straight to the last step, where its result is loaded; a new request
// is taken only in idle. A place request runs, after acceptance, for each page tried, a setup
// step and, for each top row tried, a fetch of height rows, a drain step and a compare step per
// column position; a hit adds a read and a write of each of its rows, then the last step loads
// the result. The single bitmap read port and the shared window compare keep these steps serial.
// Reset clears the bitmap at once; a result that is not taken holds the block in its last step.
module first_fit_rectangle_allocator_core #(
  parameter int MAX_COLUMNS = ffra_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = ffra_pkg::MAX_ROWS_DEF,
  parameter int PAGE_COUNT  = ffra_pkg::PAGE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [4:0] item_width, [9:5] item_height, rest zero
  input  logic        s_tuser,   // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] page_index, [4:1] column_pos, [8:5] row_pos, rest zero
  output logic        m_tuser,   // [0] placed
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = PAGE_COUNT * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ffra_pkg::cfg_t cfg;

  logic                   bm_clear;
  logic                   bm_rd_en;
  logic [AW-1:0]          bm_rd_addr;
  logic [MAX_COLUMNS-1:0] bm_rd_data;
  logic                   bm_wr_en;
  logic [AW-1:0]          bm_wr_addr;
  logic [MAX_COLUMNS-1:0] bm_wr_data;
  logic                   out_page;
  logic [3:0]             out_col;
  logic [3:0]             out_row;
  logic                   cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.second_en   <= 1'b0;
      cfg.first_cols  <= 5'd4;
      cfg.first_rows  <= 5'd3;
      cfg.second_cols <= 5'd0;
      cfg.second_rows <= 5'd0;
    end else if (cfg_write) begin
      case (paddr[4:2])
        ffra_pkg::REG_SECOND_EN:   cfg.second_en   <= pwdata[0];
        ffra_pkg::REG_FIRST_COLS:  cfg.first_cols  <= pwdata[4:0];
        ffra_pkg::REG_FIRST_ROWS:  cfg.first_rows  <= pwdata[4:0];
        ffra_pkg::REG_SECOND_COLS: cfg.second_cols <= pwdata[4:0];
        ffra_pkg::REG_SECOND_ROWS: cfg.second_rows <= pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      ffra_pkg::REG_SECOND_EN:   prdata = 32'(cfg.second_en);
      ffra_pkg::REG_FIRST_COLS:  prdata = 32'(cfg.first_cols);
      ffra_pkg::REG_FIRST_ROWS:  prdata = 32'(cfg.first_rows);
      ffra_pkg::REG_SECOND_COLS: prdata = 32'(cfg.second_cols);
      ffra_pkg::REG_SECOND_ROWS: prdata = 32'(cfg.second_rows);
      default:                   prdata = '0;
    endcase
  end

  ffra_bitmap #(
    .DEPTH (DEPTH),
    .WIDTH (MAX_COLUMNS)
  ) u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .clear   (bm_clear),
    .rd_en   (bm_rd_en),
    .rd_addr (bm_rd_addr),
    .rd_data (bm_rd_data),
    .wr_en   (bm_wr_en),
    .wr_addr (bm_wr_addr),
    .wr_data (bm_wr_data)
  );

  ffra_seq #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .PAGE_COUNT  (PAGE_COUNT)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_command (s_tuser),
    .in_width   (s_tdata[4:0]),
    .in_height  (s_tdata[9:5]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_placed (m_tuser),
    .out_page   (out_page),
    .out_col    (out_col),
    .out_row    (out_row),
    .bm_clear   (bm_clear),
    .bm_rd_en   (bm_rd_en),
    .bm_rd_addr (bm_rd_addr),
    .bm_rd_data (bm_rd_data),
    .bm_wr_en   (bm_wr_en),
    .bm_wr_addr (bm_wr_addr),
    .bm_wr_data (bm_wr_data)
  );

  assign m_tdata = {7'd0, out_row, out_col, out_page};

endmodule

FILE: hdl/ffra_checker.sv
module ffra_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser
);

  // A stalled result keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // A result that is not a placement carries no position.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 16'd0)
    else $error("unplaced result carries a position");

  // The padding above the row field stays zero.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:9] == 7'd0)
    else $error("result padding is not zero");

  // A new request is not taken while the previous one is in progress.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while the previous one is in progress");

  // Reset leaves no result pending.
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

endmodule

bind first_fit_rectangle_allocator_core ffra_checker u_checker (.*);

FILE: dv/tb_first_fit_rectangle_allocator_core.sv
`timescale 1ns / 100ps

module tb_first_fit_rectangle_allocator_core;

  localparam int STALL_LIMIT     = 20000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 50;
  localparam int PHASES          = 9;
  localparam int PHASE_ITEMS     = 61;
  localparam int REG_COUNT       = 5;
  localparam int COLUMNS         = ffra_pkg::MAX_COLUMNS_DEF;
  localparam int ROWS            = ffra_pkg::MAX_ROWS_DEF;
  localparam int PAGES           = ffra_pkg::PAGE_COUNT_DEF;
  localparam int DIM_W           = ffra_pkg::DIM_W;

  typedef struct packed {
    logic       placed;
    logic       page;
    logic [3:0] column;
    logic [3:0] row;
  } alloc_result_t;

  typedef struct {
    bit            is_cfg;
    logic [2:0]    reg_index;
    logic [31:0]   value;
    logic          cmd;
    logic [4:0]    item_w;
    logic [4:0]    item_h;
    bit            fixed;
    alloc_result_t fixed_res;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [COLUMNS-1:0] occupancy [PAGES][ROWS];
  ffra_pkg::cfg_t     model_cfg;
  alloc_result_t      expected_results [$];
  stim_row_t          directed [$];
  int                 failures;
  bit                 quiet_mode;
  bit                 hold_off_req;

  first_fit_rectangle_allocator_core u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clamp_dim(input logic [4:0] v, input int limit);
    return (int'(v) > limit) ? limit : int'(v);
  endfunction

  function automatic bit fit_page(input int pg, input int cols, input int rows,
                                  input int w, input int h,
                                  output int col_at, output int row_at);
    logic [COLUMNS-1:0] span;
    bit                 all_free;
    col_at = 0;
    row_at = 0;
    if (w > cols || h > rows) return 1'b0;
    for (int y = 0; y + h <= rows; y++) begin
      for (int x = 0; x + w <= cols; x++) begin
        span = COLUMNS'(((64'd1 << w) - 64'd1) << x);
        all_free = 1'b1;
        for (int r = y; r < y + h; r++) begin
          if ((occupancy[pg][r] & span) != '0) all_free = 1'b0;
        end
        if (all_free) begin
          for (int r = y; r < y + h; r++) occupancy[pg][r] |= span;
          col_at = x;
          row_at = y;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic alloc_result_t predict_allocation(input logic cmd, input logic [4:0] w_in,
                                                       input logic [4:0] h_in);
    alloc_result_t res;
    int            w;
    int            h;
    int            cx;
    int            ry;
    res = '0;
    if (cmd == ffra_pkg::CMD_CLEAR) begin
      foreach (occupancy[p, r]) occupancy[p][r] = '0;
      return res;
    end
    w = (w_in == 5'd0) ? 1 : int'(w_in);
    h = (h_in == 5'd0) ? 1 : int'(h_in);
    if (fit_page(0, clamp_dim(model_cfg.first_cols, COLUMNS),
                 clamp_dim(model_cfg.first_rows, ROWS), w, h, cx, ry)) begin
      res.placed = 1'b1;
      res.column = 4'(cx);
      res.row    = 4'(ry);
    end else if (PAGES > 1 && model_cfg.second_en &&
                 fit_page(1, clamp_dim(model_cfg.second_cols, COLUMNS),
                          clamp_dim(model_cfg.second_rows, ROWS), w, h, cx, ry)) begin
      res.placed = 1'b1;
      res.page   = 1'b1;
      res.column = 4'(cx);
      res.row    = 4'(ry);
    end
    return res;
  endfunction

  function automatic void apply_register(input logic [2:0] index, input logic [31:0] value);
    case (index)
      ffra_pkg::REG_SECOND_EN:   model_cfg.second_en   = value[0];
      ffra_pkg::REG_FIRST_COLS:  model_cfg.first_cols  = value[DIM_W-1:0];
      ffra_pkg::REG_FIRST_ROWS:  model_cfg.first_rows  = value[DIM_W-1:0];
      ffra_pkg::REG_SECOND_COLS: model_cfg.second_cols = value[DIM_W-1:0];
      ffra_pkg::REG_SECOND_ROWS: model_cfg.second_rows = value[DIM_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic stim_row_t cfg_row(input logic [2:0] index, input logic [31:0] value);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg    = 1'b1;
    row.reg_index = index;
    row.value     = value;
    return row;
  endfunction

  function automatic stim_row_t req_row(input logic cmd, input logic [4:0] w,
                                        input logic [4:0] h);
    stim_row_t row;
    row = '{default: '0};
    row.cmd    = cmd;
    row.item_w = w;
    row.item_h = h;
    return row;
  endfunction

  function automatic stim_row_t exp_row(input logic cmd, input logic [4:0] w,
                                        input logic [4:0] h, input logic placed,
                                        input logic page, input logic [3:0] column,
                                        input logic [3:0] row_at);
    stim_row_t row;
    row = req_row(cmd, w, h);
    row.fixed     = 1'b1;
    row.fixed_res = '{placed: placed, page: page, column: column, row: row_at};
    return row;
  endfunction

  function automatic logic [4:0] pick_dimension();
    case ($urandom_range(0, 9))
      0:       return 5'd0;
      1:       return 5'd16;
      2:       return 5'($urandom_range(17, 31));
      default: return 5'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [4:0] pick_size();
    case ($urandom_range(0, 19))
      0:       return 5'($urandom_range(0, 31));
      1:       return 5'd16;
      default: return 5'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic write_register(input logic [2:0] index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_register(index, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_request(input logic cmd, input logic [4:0] w, input logic [4:0] h,
                              input bit fixed, input alloc_result_t fixed_res);
    alloc_result_t predicted;
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {6'd0, h, w};
    do @(posedge clk); while (!s_tready);
    predicted = predict_allocation(cmd, w, h);
    expected_results.push_back(fixed ? fixed_res : predicted);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    alloc_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with no request pending: placed %0d tdata %h", m_tuser, m_tdata);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (m_tuser !== want.placed) begin
          $error("placed: expected %0d, actual %0d", want.placed, m_tuser);
          failures++;
        end
        if (m_tdata[0] !== want.page) begin
          $error("page_index: expected %0d, actual %0d", want.page, m_tdata[0]);
          failures++;
        end
        if (m_tdata[4:1] !== want.column) begin
          $error("column_pos: expected %0d, actual %0d", want.column, m_tdata[4:1]);
          failures++;
        end
        if (m_tdata[8:5] !== want.row) begin
          $error("row_pos: expected %0d, actual %0d", want.row, m_tdata[8:5]);
          failures++;
        end
      end
    end
  end

  initial begin : result_sink
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        m_tready <= 1'b1;
      end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] dims [REG_COUNT];
    failures     = 0;
    quiet_mode   = 1'b0;
    hold_off_req = 1'b0;
    foreach (occupancy[p, r]) occupancy[p][r] = '0;
    model_cfg = '{second_en: 1'b0, first_cols: 5'd4, first_rows: 5'd3,
                  second_cols: 5'd0, second_rows: 5'd0};
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= ffra_pkg::CMD_CLEAR;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The page after reset is 4 by 3 and the second page is off.
    directed.push_back(exp_row(ffra_pkg::CMD_PLACE, 5'd1, 5'd1, 1'b1, 1'b0, 4'd0, 4'd0));
    directed.push_back(exp_row(ffra_pkg::CMD_PLACE, 5'd4, 5'd3, 1'b0, 1'b0, 4'd0, 4'd0));
    directed.push_back(exp_row(ffra_pkg::CMD_CLEAR, 5'd16, 5'd16, 1'b0, 1'b0, 4'd0, 4'd0));
    directed.push_back(exp_row(ffra_pkg::CMD_PLACE, 5'd4, 5'd3, 1'b1, 1'b0, 4'd0, 4'd0));
    directed.push_back(exp_row(ffra_pkg::CMD_PLACE, 5'd1, 5'd1, 1'b0, 1'b0, 4'd0, 4'd0));
    directed.push_back(exp_row(ffra_pkg::CMD_PLACE, 5'd0, 5'd0, 1'b0, 1'b0, 4'd0, 4'd0));
    directed.push_back(exp_row(ffra_pkg::CMD_CLEAR, 5'd31, 5'd31, 1'b0, 1'b0, 4'd0, 4'd0));
    directed.push_back(exp_row(ffra_pkg::CMD_PLACE, 5'd0, 5'd0, 1'b1, 1'b0, 4'd0, 4'd0));
    directed.push_back(req_row(ffra_pkg::CMD_PLACE, 5'd0, 5'd1));
    directed.push_back(exp_row(ffra_pkg::CMD_PLACE, 5'd5, 5'd1, 1'b0, 1'b0, 4'd0, 4'd0));
    directed.push_back(exp_row(ffra_pkg::CMD_PLACE, 5'd31, 5'd31, 1'b0, 1'b0, 4'd0, 4'd0));
    directed.push_back(cfg_row(ffra_pkg::REG_SECOND_EN, 32'd1));
    directed.push_back(cfg_row(ffra_pkg::REG_SECOND_COLS, 32'd16));
    directed.push_back(cfg_row(ffra_pkg::REG_SECOND_ROWS, 32'd16));
    directed.push_back(cfg_row(ffra_pkg::REG_FIRST_COLS, 32'd0));
    directed.push_back(exp_row(ffra_pkg::CMD_PLACE, 5'd16, 5'd16, 1'b1, 1'b1, 4'd0, 4'd0));
    directed.push_back(exp_row(ffra_pkg::CMD_PLACE, 5'd1, 5'd1, 1'b0, 1'b0, 4'd0, 4'd0));
    directed.push_back(exp_row(ffra_pkg::CMD_CLEAR, 5'd0, 5'd0, 1'b0, 1'b0, 4'd0, 4'd0));
    directed.push_back(cfg_row(ffra_pkg::REG_FIRST_COLS, 32'd31));
    directed.push_back(cfg_row(ffra_pkg::REG_FIRST_ROWS, 32'd31));
    directed.push_back(cfg_row(ffra_pkg::REG_SECOND_COLS, 32'd20));
    directed.push_back(cfg_row(ffra_pkg::REG_SECOND_ROWS, 32'd0));
    directed.push_back(cfg_row(3'(REG_COUNT), 32'd1));
    directed.push_back(exp_row(ffra_pkg::CMD_PLACE, 5'd16, 5'd16, 1'b1, 1'b0, 4'd0, 4'd0));
    directed.push_back(exp_row(ffra_pkg::CMD_PLACE, 5'd1, 5'd1, 1'b0, 1'b0, 4'd0, 4'd0));
    directed.push_back(exp_row(ffra_pkg::CMD_CLEAR, 5'd1, 5'd1, 1'b0, 1'b0, 4'd0, 4'd0));
    directed.push_back(cfg_row(ffra_pkg::REG_FIRST_ROWS, 32'd1));
    directed.push_back(req_row(ffra_pkg::CMD_PLACE, 5'd2, 5'd1));
    directed.push_back(req_row(ffra_pkg::CMD_PLACE, 5'd2, 5'd1));
    directed.push_back(cfg_row(ffra_pkg::REG_FIRST_COLS, 32'd2));
    directed.push_back(req_row(ffra_pkg::CMD_PLACE, 5'd2, 5'd1));
    directed.push_back(cfg_row(ffra_pkg::REG_FIRST_COLS, 32'd6));
    directed.push_back(req_row(ffra_pkg::CMD_PLACE, 5'd2, 5'd1));
    directed.push_back(cfg_row(ffra_pkg::REG_SECOND_EN, 32'd0));
    directed.push_back(cfg_row(ffra_pkg::REG_FIRST_COLS, 32'd16));
    directed.push_back(cfg_row(ffra_pkg::REG_FIRST_ROWS, 32'd16));
    directed.push_back(cfg_row(ffra_pkg::REG_SECOND_COLS, 32'd16));
    directed.push_back(cfg_row(ffra_pkg::REG_SECOND_ROWS, 32'd16));
    directed.push_back(req_row(ffra_pkg::CMD_PLACE, 5'd1, 5'd16));
    directed.push_back(req_row(ffra_pkg::CMD_PLACE, 5'd16, 5'd1));
    directed.push_back(exp_row(ffra_pkg::CMD_CLEAR, 5'd0, 5'd0, 1'b0, 1'b0, 4'd0, 4'd0));

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        wait_idle();
        write_register(directed[i].reg_index, directed[i].value);
      end else begin
        send_request(directed[i].cmd, directed[i].item_w, directed[i].item_h,
                     directed[i].fixed, directed[i].fixed_res);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: dims = '{32'd1, 32'd16, 32'd16, 32'd16, 32'd16};
        1: dims = '{32'd1, 32'd0, 32'd0, 32'd31, 32'd31};
        default: begin
          dims[0] = 32'($urandom_range(0, 1));
          for (int k = 1; k < REG_COUNT; k++) dims[k] = 32'(pick_dimension());
        end
      endcase
      write_register(ffra_pkg::REG_SECOND_EN, dims[0]);
      write_register(ffra_pkg::REG_FIRST_COLS, dims[1]);
      write_register(ffra_pkg::REG_FIRST_ROWS, dims[2]);
      write_register(ffra_pkg::REG_SECOND_COLS, dims[3]);
      write_register(ffra_pkg::REG_SECOND_ROWS, dims[4]);
      if (phase == 2) hold_off_req = 1'b1;
      if (phase == PHASES - 1) quiet_mode = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 9) == 0)
          send_request(ffra_pkg::CMD_CLEAR, 5'($urandom_range(0, 31)),
                       5'($urandom_range(0, 31)), 1'b0, '0);
        else
          send_request(ffra_pkg::CMD_PLACE, pick_size(), pick_size(), 1'b0, '0);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

FILE: sim.f
hdl/ffra_pkg.sv
hdl/ffra_bitmap.sv
hdl/ffra_seq.sv
hdl/first_fit_rectangle_allocator_core.sv
hdl/ffra_checker.sv
dv/tb_first_fit_rectangle_allocator_core.sv
